// File: hw/rtl/mfps_pkg.sv
`default_nettype none

package mfps_pkg;

   localparam int ELEM_W = 16;
   localparam int SUM_W  = 24;
   localparam int SIZE_W = 8;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [SIZE_W-1:0]        size_type;

   localparam sum_type  SUM_MAX    = 24'sh7F_FFFF;
   localparam size_type SIZE_RESET = 8'd1;

endpackage

`default_nettype wire

// File: hw/rtl/mfps_ram.sv
`default_nettype none

module mfps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/min_falling_path_sum_top.sv
`default_nettype none

// Minimum falling-path sum of a square signed matrix streamed in row-major order, one element
// per transfer, with the side length taken from the size register (0 acts as 1, values above
// MAX_N act as MAX_N). The block takes one element every clock cycle unless a result waits
// untaken or a size write is under way: each element needs one read of the row store (a
// MAX_N x 24 RAM with one write and one registered read port), and the neighbors above come
// from a three-entry window fed by that read port, with a bypass for a value written at the
// previous edge. The result leaves through an output register, valid in the cycle after the
// last element is taken; the next matrix may follow at once. The row store needs no clearing
// after reset. A write to the size register restarts the block and drops any partial matrix.
module min_falling_path_sum_top
   import mfps_pkg::*;
#(
   parameter int MAX_N = 128
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire elem_type       req_element,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output sum_type             rsp_min_path_sum,
   input  wire logic           csr_wr_en,
   input  wire size_type       csr_wr_data
);

   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int NW = $clog2(MAX_N + 1);
   localparam int SW = (NW > SIZE_W) ? NW : SIZE_W;

   size_type        size_ff;
   logic [NW-1:0]   n_eff;
   logic [AW-1:0]   col_ff, col_in;
   logic [AW-1:0]   row_ff, row_in;
   sum_type         left_ff, left_in;
   sum_type         mid_ff, mid_in;
   sum_type         first_sum_ff, first_sum_in;
   sum_type         min_ff, min_in;
   logic            rsp_valid_ff, rsp_valid_in;
   sum_type         rsp_data_ff, rsp_data_in;
   logic            wr_en_ff;
   logic [AW-1:0]   wr_addr_ff;
   sum_type         wr_data_ff;
   logic [AW-1:0]   rd_addr_ff;

   logic            xfer;
   logic            ram_wr_en;
   logic [AW-1:0]   rd_addr;
   sum_type         ram_rd_data;
   sum_type         right_val;
   sum_type         best;
   sum_type         sum_val;
   sum_type         min_next;
   logic [NW-1:0]   col_inc;
   logic [NW-1:0]   row_inc;
   logic            col_last;
   logic            row_last;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = NW'(1);
      end else if (SW'(size_ff) > SW'(MAX_N)) begin
         n_eff = NW'(MAX_N);
      end else begin
         n_eff = NW'(SW'(size_ff));
      end
   end

   assign req_ready = (!rsp_valid_ff || rsp_ready) && !csr_wr_en;
   assign xfer      = req_valid && req_ready;
   assign ram_wr_en = xfer;

   assign col_inc  = NW'(col_ff) + NW'(1);
   assign row_inc  = NW'(row_ff) + NW'(1);
   assign col_last = (col_inc == n_eff);
   assign row_last = (row_inc == n_eff);

   assign right_val = (wr_en_ff && (wr_addr_ff == rd_addr_ff)) ? wr_data_ff : ram_rd_data;

   always_comb begin
      best = mid_ff;
      if ((col_ff != '0) && (left_ff < best)) begin
         best = left_ff;
      end
      if (!col_last && (right_val < best)) begin
         best = right_val;
      end
      if (row_ff == '0) begin
         sum_val = {{(SUM_W-ELEM_W){req_element[ELEM_W-1]}}, req_element};
      end else begin
         sum_val = {{(SUM_W-ELEM_W){req_element[ELEM_W-1]}}, req_element} + best;
      end
      min_next = (row_last && (sum_val < min_ff)) ? sum_val : min_ff;
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      first_sum_in = first_sum_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
         min_in = SUM_MAX;
      end else if (xfer) begin
         min_in = min_next;
         if (col_ff == '0) begin
            first_sum_in = sum_val;
         end
         if (!col_last) begin
            col_in  = col_ff + AW'(1);
            left_in = mid_ff;
            mid_in  = right_val;
         end else begin
            col_in = '0;
            mid_in = (col_ff == '0) ? sum_val : first_sum_ff;
            if (!row_last) begin
               row_in = row_ff + AW'(1);
            end else begin
               row_in       = '0;
               min_in       = SUM_MAX;
               rsp_valid_in = 1'b1;
               rsp_data_in  = min_next;
            end
         end
      end
   end

   assign rd_addr = AW'(NW'(col_in) + NW'(1));

   mfps_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_N)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(col_ff),
      .wr_data(sum_val),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         min_ff       <= SUM_MAX;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_en_ff     <= ram_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      mid_ff       <= mid_in;
      first_sum_ff <= first_sum_in;
      rsp_data_ff  <= rsp_data_in;
      wr_addr_ff   <= col_ff;
      wr_data_ff   <= sum_val;
      rd_addr_ff   <= rd_addr;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_path_sum = rsp_data_ff;

`ifndef SYNTHESIS
   // A result appears only right after the transfer of a matrix's last element.
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(xfer && col_last && row_last))
      else $error("result appeared without a final element transfer");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      NW'(col_ff) < n_eff)
      else $error("column counter outside the matrix");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      NW'(row_ff) < n_eff)
      else $error("row counter outside the matrix");

   // A size write always restarts at the top-left element.
   a_csr_rearms: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (col_ff == '0) && (row_ff == '0) && (min_ff == SUM_MAX))
      else $error("size write did not restart the matrix");
`endif

endmodule

`default_nettype wire

// File: dv/min_falling_path_sum_top_test.sv
`default_nettype none

module min_falling_path_sum_top_test;
   import mfps_pkg::*;

   localparam int MAX_N = 128;
   localparam elem_type ELEM_LO = 16'sh8000;
   localparam elem_type ELEM_HI = 16'sh7FFF;
   localparam int RSP_HOLD_CYCLES = 150;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   elem_type req_element = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   sum_type  rsp_min_path_sum;
   logic     csr_wr_en = 1'b0;
   size_type csr_wr_data = '0;

   min_falling_path_sum_top #(
      .MAX_N(MAX_N)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_min_path_sum(rsp_min_path_sum),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   elem_type    elements_to_send [$];
   sum_type     min_sums_due [$];
   int unsigned send_idle_pct = 16;
   int unsigned rsp_idle_pct = 57;
   int unsigned rsp_hold_requests = 0;
   int unsigned mismatches = 0;
   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;

   // Path-sum predictor state.
   sum_type     above_sums [MAX_N];
   sum_type     upper_left_sum;
   int unsigned col_pos;
   int unsigned row_pos;
   sum_type     bottom_min;
   size_type    size_reg;

   function automatic int unsigned side_len(input size_type s);
      if (s == 0) return 1;
      if (s > MAX_N) return MAX_N;
      return s;
   endfunction

   function automatic elem_type rand_element();
      case ($urandom_range(7))
         0: return ELEM_LO;
         1: return ELEM_HI;
         2: return elem_type'($urandom_range(20)) - 16'sd10;
         default: return elem_type'($urandom);
      endcase
   endfunction

   task automatic rearm_path();
      col_pos = 0;
      row_pos = 0;
      upper_left_sum = '0;
      bottom_min = SUM_MAX;
   endtask

   task automatic take_element(input elem_type e);
      int unsigned n;
      int unsigned c;
      int unsigned r;
      sum_type best;
      sum_type path_sum;
      n = side_len(size_reg);
      c = (col_pos >= n) ? n - 1 : col_pos;
      r = (row_pos >= n) ? n - 1 : row_pos;
      if (r == 0) begin
         path_sum = sum_type'(e);
      end else begin
         best = above_sums[c];
         if (c > 0 && upper_left_sum < best) best = upper_left_sum;
         if (c + 1 < n && above_sums[c + 1] < best) best = above_sums[c + 1];
         path_sum = sum_type'(e) + best;
      end
      upper_left_sum = above_sums[c];
      above_sums[c] = path_sum;
      if (r == n - 1 && path_sum < bottom_min) bottom_min = path_sum;
      if (c + 1 < n) begin
         col_pos = c + 1;
         row_pos = r;
      end else if (r + 1 < n) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         min_sums_due.push_back(bottom_min);
         rearm_path();
      end
   endtask

   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (reset) begin
         size_reg = SIZE_RESET;
         for (int i = 0; i < MAX_N; i++) above_sums[i] = '0;
         rearm_path();
      end else begin
         if (rsp_fire) begin
            if (min_sums_due.size() == 0) begin
               $display("%0t: min_path_sum expected none, got %0d", $time, rsp_min_path_sum);
               mismatches++;
            end else begin
               if (rsp_min_path_sum !== min_sums_due[0]) begin
                  $display("%0t: min_path_sum expected %0d, got %0d", $time,
                     min_sums_due[0], rsp_min_path_sum);
                  mismatches++;
               end
               void'(min_sums_due.pop_front());
            end
         end
         if (csr_wr_en) begin
            size_reg = csr_wr_data;
            rearm_path();
         end
         if (req_fire) take_element(req_element);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (elements_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_element <= elements_to_send.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   int unsigned rsp_hold_left = 0;
   int unsigned rsp_hold_served = 0;

   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_hold_served != rsp_hold_requests) begin
         rsp_hold_served = rsp_hold_served + 1;
         rsp_hold_left = RSP_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (elements_to_send.size() != 0 || req_valid || min_sums_due.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_size(input size_type s);
      @(negedge clock);
      csr_wr_data <= s;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) elements_to_send.push_back(rand_element());
   endtask

   task automatic random_phase(input int unsigned item_goal);
      int unsigned sent;
      int unsigned n;
      int unsigned extra;
      size_type sz;
      sent = 0;
      while (sent < item_goal) begin
         wait_idle();
         case ($urandom_range(9))
            0: sz = '0;
            1: sz = size_type'($urandom_range(9, 16));
            default: sz = size_type'($urandom_range(1, 8));
         endcase
         write_size(sz);
         n = side_len(sz);
         repeat ($urandom_range(1, 3)) begin
            queue_random(n * n);
            sent += n * n;
         end
         if (n > 1 && $urandom_range(3) == 0) begin
            extra = $urandom_range(1, n * n - 1);
            queue_random(extra);
            sent += extra;
         end
      end
   endtask

   initial begin : stimulus
      elem_type grid3 [9];
      grid3 = '{16'sd2, 16'sd1, 16'sd3, 16'sd6, 16'sd5, 16'sd4, ELEM_HI, 16'sd8, ELEM_LO};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset size is one, so every element is a whole matrix.
      elements_to_send.push_back(ELEM_LO);
      elements_to_send.push_back(ELEM_HI);
      elements_to_send.push_back('0);
      elements_to_send.push_back(-16'sd1);
      wait_idle();
      write_size('0);
      elements_to_send.push_back(16'sd5);
      elements_to_send.push_back(-16'sd7);
      wait_idle();
      write_size(8'd3);
      foreach (grid3[i]) elements_to_send.push_back(grid3[i]);
      wait_idle();
      write_size(8'd2);
      queue_random(3);
      wait_idle();
      write_size(8'd2);
      elements_to_send.push_back(ELEM_HI);
      elements_to_send.push_back(ELEM_LO);
      elements_to_send.push_back(ELEM_LO);
      elements_to_send.push_back(ELEM_HI);
      wait_idle();

      // Stall the result side long enough for the block to back up its input.
      write_size(8'd1);
      rsp_hold_requests++;
      queue_random(40);
      wait_idle();

      random_phase(200);
      wait_idle();
      send_idle_pct = 57;
      rsp_idle_pct = 16;
      random_phase(200);
      wait_idle();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(200);

      // An oversized side acts as the row store depth, so the first row wraps after MAX_N.
      wait_idle();
      write_size(8'd255);
      queue_random(MAX_N + 2);
      wait_idle();

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
